// File: sv/sspsw_pkg.sv
// ----------------------------------------------------------------------------
// sspsw_pkg
// shared types, codes and helpers for the sah split plane sweep
// ----------------------------------------------------------------------------
package sspsw_pkg;

    localparam int CoordW = 16;
    localparam int CountW = 16;
    localparam int CntW   = 17;
    localparam int AreaW  = 35;
    localparam int ProdW  = 52;
    localparam int SumW   = 53;
    localparam int CostW  = 62;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_PLANAR = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] REG_BOX_MIN_X   = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y   = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z   = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X   = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y   = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z   = 3'd5;
    localparam logic [2:0] REG_TRI_COUNT   = 3'd6;

    localparam logic [CostW-1:0] COST_MAX = {CostW{1'b1}};

    typedef struct packed {
        logic [1:0]               axis;
        logic signed [CoordW-1:0] position;
        logic [1:0]               kind;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic [1:0]               split_axis;
        logic signed [CoordW-1:0] split_position;
        logic                     planar_side;
        logic [CostW-1:0]         scaled_cost;
        logic                     make_leaf;
    } t_out;

    typedef struct packed {
        logic [2:0][CoordW-1:0] box_min;
        logic [2:0][CoordW-1:0] box_max;
        logic [CountW-1:0]      tri_count;
    } t_cfg;

    typedef struct packed {
        logic                     close;
        logic                     fin;
        logic [1:0]               axis;
        logic signed [CoordW-1:0] position;
        logic [CntW-1:0]          left;
        logic [CntW-1:0]          right;
        logic [CntW-1:0]          planar;
    } t_job;

    function automatic logic [CntW-1:0] cnt_add(input logic [CntW-1:0] a,
                                                input logic [CntW-1:0] b);
        logic [CntW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
    endfunction

    function automatic logic [CostW-1:0] times500(input logic [SumW-1:0] x);
        logic [CostW-1:0] w;
        w = CostW'(x);
        return (w << 9) - (w << 3) - (w << 2);
    endfunction

endpackage

// File: sv/sspsw_queue.sv
// ----------------------------------------------------------------------------
// sspsw_queue
// four-entry job queue between the front end and the scoring back end
// ----------------------------------------------------------------------------
module sspsw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sspsw_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output sspsw_pkg::t_job   o_job,
    output logic              o_empty
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    sspsw_pkg::t_job r_mem [Depth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [PtrW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (PtrW+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule

// File: sv/sspsw_front.sv
// ----------------------------------------------------------------------------
// sspsw_front
// groups events by plane, keeps left and right counts, issues scoring jobs
// ----------------------------------------------------------------------------
module sspsw_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  sspsw_pkg::t_in                 i_item,
    input  logic [sspsw_pkg::CountW-1:0]   i_tri_count,
    output logic                           o_job_push,
    output sspsw_pkg::t_job                o_job,
    input  logic                           i_job_full
);

    localparam int CntW = sspsw_pkg::CntW;

    logic [1:0]                          r_ga,  n_ga;
    logic signed [sspsw_pkg::CoordW-1:0] r_gp,  n_gp;
    logic                                r_open, n_open;
    logic [CntW-1:0]                     r_sc, n_sc, r_pc, n_pc, r_ec, n_ec;
    logic [CntW-1:0]                     r_lt, n_lt, r_rt, n_rt;
    sspsw_pkg::t_job                     r_pend, n_pend;
    logic                                r_pend_v, n_pend_v;

    logic            accept, valid, newkey, close_old;
    logic [CntW-1:0] leave, rt_c, leave2, rt2;
    sspsw_pkg::t_job old_job, fin_job;

    always_comb begin
        accept    = i_push && !o_full;
        valid     = (i_item.axis != sspsw_pkg::AXIS_NONE) &&
                    (i_item.kind != sspsw_pkg::KIND_NONE);
        newkey    = !(r_open && i_item.axis == r_ga && i_item.position == r_gp);
        close_old = valid && newkey && r_open;
        leave     = sspsw_pkg::cnt_add(r_pc, r_ec);
        rt_c      = (r_rt > leave) ? r_rt - leave : '0;

        old_job          = '0;
        old_job.close    = 1'b1;
        old_job.axis     = r_ga;
        old_job.position = r_gp;
        old_job.left     = r_lt;
        old_job.right    = rt_c;
        old_job.planar   = r_pc;

        n_ga = r_ga; n_gp = r_gp; n_open = r_open;
        n_sc = r_sc; n_pc = r_pc; n_ec = r_ec; n_lt = r_lt; n_rt = r_rt;
        if (valid) begin
            if (newkey) begin
                if (r_open) begin
                    n_rt = rt_c;
                    n_lt = sspsw_pkg::cnt_add(r_lt, sspsw_pkg::cnt_add(r_sc, r_pc));
                end
                if (!r_open || i_item.axis != r_ga) begin
                    n_lt = '0;
                    n_rt = CntW'(i_tri_count);
                end
                n_ga   = i_item.axis;
                n_gp   = i_item.position;
                n_open = 1'b1;
                n_sc   = '0;
                n_pc   = '0;
                n_ec   = '0;
            end
            case (i_item.kind)
                sspsw_pkg::KIND_START:  n_sc = sspsw_pkg::cnt_add(n_sc, CntW'(1));
                sspsw_pkg::KIND_PLANAR: n_pc = sspsw_pkg::cnt_add(n_pc, CntW'(1));
                default:                n_ec = sspsw_pkg::cnt_add(n_ec, CntW'(1));
            endcase
        end

        leave2           = sspsw_pkg::cnt_add(n_pc, n_ec);
        rt2              = (n_rt > leave2) ? n_rt - leave2 : '0;
        fin_job          = '0;
        fin_job.close    = n_open;
        fin_job.fin      = 1'b1;
        fin_job.axis     = n_open ? n_ga : sspsw_pkg::AXIS_X;
        fin_job.position = n_gp;
        fin_job.left     = n_lt;
        fin_job.right    = rt2;
        fin_job.planar   = n_pc;

        if (i_item.last) begin
            n_ga = '0; n_gp = '0; n_open = 1'b0;
            n_sc = '0; n_pc = '0; n_ec = '0; n_lt = '0; n_rt = '0;
        end

        o_job_push = 1'b0;
        o_job      = fin_job;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        if (r_pend_v) begin
            o_job = r_pend;
            if (!i_job_full) begin
                o_job_push = 1'b1;
                n_pend_v   = 1'b0;
            end
        end else if (accept) begin
            if (close_old) begin
                o_job_push = 1'b1;
                o_job      = old_job;
                n_pend     = fin_job;
                n_pend_v   = i_item.last;
            end else if (i_item.last) begin
                o_job_push = 1'b1;
            end
        end
    end

    assign o_full = i_job_full || r_pend_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ga <= '0; r_gp <= '0; r_open <= 1'b0;
            r_sc <= '0; r_pc <= '0; r_ec <= '0; r_lt <= '0; r_rt <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (accept) begin
                r_ga <= n_ga; r_gp <= n_gp; r_open <= n_open;
                r_sc <= n_sc; r_pc <= n_pc; r_ec <= n_ec;
                r_lt <= n_lt; r_rt <= n_rt;
            end
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

// File: sv/sspsw_back.sv
// ----------------------------------------------------------------------------
// sspsw_back
// scores closed planes on one shared multiplier, keeps the best, emits result
// ----------------------------------------------------------------------------
module sspsw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sspsw_pkg::t_cfg   i_cfg,
    input  sspsw_pkg::t_job   i_job,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    output logic              empty,
    input  logic              pop,
    output sspsw_pkg::t_out   o_res
);

    localparam int CoordW = sspsw_pkg::CoordW;
    localparam int CntW   = sspsw_pkg::CntW;
    localparam int AreaW  = sspsw_pkg::AreaW;
    localparam int ProdW  = sspsw_pkg::ProdW;
    localparam int SumW   = sspsw_pkg::SumW;
    localparam int CostW  = sspsw_pkg::CostW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_P12, ST_PA, ST_LA, ST_RA, ST_SL0, ST_SL1,
        ST_SR0, ST_SR1, ST_COST, ST_PICK, ST_LEAF0, ST_LEAF1, ST_EMIT
    } t_state;

    t_state                   r_state;
    sspsw_pkg::t_job          r_job;
    logic [CoordW-1:0]        r_ea, r_e1, r_e2, r_ll, r_lr;
    logic [CoordW:0]          r_s;
    logic [CntW-1:0]          r_nl, r_nlp, r_nr, r_nrp;
    logic [ProdW-1:0]         r_prod;
    logic [AreaW-1:0]         r_p12, r_pa, r_la, r_ra;
    logic [SumW-1:0]          r_acc, r_suml;
    logic [CostW-1:0]         r_cl, r_cr, r_leaf;
    logic [CostW-1:0]         r_best_cost;
    logic [1:0]               r_best_axis;
    logic signed [CoordW-1:0] r_best_pos;
    logic                     r_best_side;
    logic                     r_out_v;
    sspsw_pkg::t_out          r_out;

    logic [2:0][CoordW-1:0]   ext;
    logic [AreaW-1:0]         op_a;
    logic [CntW-1:0]          op_b;
    logic [AreaW-1:0]         area_n;
    logic [SumW-1:0]          sumr;
    logic [CostW-1:0]         pa_w, fl_pa, fr_pa, c_min;
    logic                     five_l, five_r;
    logic signed [CoordW-1:0] bmin, bmax, pcl;
    logic                     degen;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext[i] = ($signed(i_cfg.box_max[i]) > $signed(i_cfg.box_min[i])) ?
                     CoordW'(i_cfg.box_max[i] - i_cfg.box_min[i]) : '0;
        end
        bmin  = $signed(i_cfg.box_min[r_job.axis]);
        bmax  = $signed(i_cfg.box_max[r_job.axis]);
        degen = !(bmax > bmin);
        pcl   = r_job.position;
        if (pcl < bmin) pcl = bmin;
        if (pcl > bmax) pcl = bmax;

        op_a = AreaW'(r_e1);
        op_b = CntW'(r_e2);
        case (r_state)
            ST_PA:    begin op_a = AreaW'(r_ea); op_b = CntW'(r_s); end
            ST_LA:    begin op_a = AreaW'(r_ll); op_b = CntW'(r_s); end
            ST_RA:    begin op_a = AreaW'(r_lr); op_b = CntW'(r_s); end
            ST_SL0:   begin op_a = r_la; op_b = r_nlp; end
            ST_SL1:   begin op_a = r_ra; op_b = r_nr;  end
            ST_SR0:   begin op_a = r_la; op_b = r_nl;  end
            ST_SR1:   begin op_a = r_ra; op_b = r_nrp; end
            ST_LEAF0: begin op_a = r_pa; op_b = CntW'(i_cfg.tri_count); end
            default:  ;
        endcase

        area_n = (r_p12 + r_prod[AreaW-1:0]) << 1;
        sumr   = r_acc + SumW'(r_prod);
        pa_w   = CostW'(r_pa);
        five_l = (r_nlp != '0) && (r_nr != '0);
        five_r = (r_nl != '0) && (r_nrp != '0);
        fl_pa  = (pa_w << 2) + (five_l ? pa_w : '0);
        fr_pa  = (pa_w << 2) + (five_r ? pa_w : '0);
        c_min  = (r_cl < r_cr) ? r_cl : r_cr;
    end

    assign o_job_pop = (r_state == ST_IDLE) && !i_job_empty;
    assign empty     = !r_out_v;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_best_cost <= sspsw_pkg::COST_MAX;
            r_best_axis <= '0;
            r_best_pos  <= '0;
            r_best_side <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (pop && r_out_v) r_out_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_job   <= i_job;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    unique case (r_job.axis)
                        sspsw_pkg::AXIS_Y: begin
                            r_ea <= ext[1]; r_e1 <= ext[2]; r_e2 <= ext[0];
                            r_s  <= {1'b0, ext[2]} + {1'b0, ext[0]};
                        end
                        sspsw_pkg::AXIS_Z: begin
                            r_ea <= ext[2]; r_e1 <= ext[0]; r_e2 <= ext[1];
                            r_s  <= {1'b0, ext[0]} + {1'b0, ext[1]};
                        end
                        default: begin
                            r_ea <= ext[0]; r_e1 <= ext[1]; r_e2 <= ext[2];
                            r_s  <= {1'b0, ext[1]} + {1'b0, ext[2]};
                        end
                    endcase
                    r_ll  <= degen ? '0 : CoordW'(pcl - bmin);
                    r_lr  <= degen ? '0 : CoordW'(bmax - pcl);
                    r_nl  <= r_job.left;
                    r_nlp <= sspsw_pkg::cnt_add(r_job.left, r_job.planar);
                    r_nr  <= r_job.right;
                    r_nrp <= sspsw_pkg::cnt_add(r_job.right, r_job.planar);
                    r_state <= ST_P12;
                end
                ST_P12: r_state <= ST_PA;
                ST_PA: begin
                    r_p12   <= AreaW'(r_prod);
                    r_state <= ST_LA;
                end
                ST_LA: begin
                    r_pa    <= area_n;
                    r_state <= r_job.close ? ST_RA : ST_LEAF0;
                end
                ST_RA: begin
                    r_la    <= area_n;
                    r_state <= ST_SL0;
                end
                ST_SL0: begin
                    r_ra    <= area_n;
                    r_state <= ST_SL1;
                end
                ST_SL1: begin
                    r_acc   <= SumW'(r_prod);
                    r_state <= ST_SR0;
                end
                ST_SR0: begin
                    r_suml  <= sumr;
                    r_state <= ST_SR1;
                end
                ST_SR1: begin
                    r_acc   <= SumW'(r_prod);
                    r_state <= ST_COST;
                end
                ST_COST: begin
                    r_cl    <= sspsw_pkg::times500(r_suml) + fl_pa;
                    r_cr    <= sspsw_pkg::times500(sumr) + fr_pa;
                    r_state <= ST_PICK;
                end
                ST_PICK: begin
                    if (c_min < r_best_cost) begin
                        r_best_cost <= c_min;
                        r_best_axis <= r_job.axis;
                        r_best_pos  <= r_job.position;
                        r_best_side <= !(r_cl < r_cr);
                    end
                    r_state <= r_job.fin ? ST_LEAF0 : ST_IDLE;
                end
                ST_LEAF0: r_state <= ST_LEAF1;
                ST_LEAF1: begin
                    r_leaf  <= sspsw_pkg::times500(SumW'(r_prod));
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!r_out_v) begin
                        r_out_v              <= 1'b1;
                        r_out.split_axis     <= r_best_axis;
                        r_out.split_position <= r_best_pos;
                        r_out.planar_side    <= r_best_side;
                        r_out.scaled_cost    <= r_best_cost;
                        r_out.make_leaf      <= r_best_cost > r_leaf;
                        r_best_cost          <= sspsw_pkg::COST_MAX;
                        r_best_axis          <= '0;
                        r_best_pos           <= '0;
                        r_best_side          <= 1'b0;
                        r_state              <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ProdW'(op_a) * ProdW'(op_b);
    end

endmodule

// File: sv/sah_split_plane_sweep_core.sv
// ----------------------------------------------------------------------------
// sah_split_plane_sweep_core
// kd-tree split plane search by surface area heuristic over sorted events
// ----------------------------------------------------------------------------
// Events enter at one per cycle while they stay within a plane group and
// the job queue has room; the front end counts them and hands each closed
// plane to a four-entry job queue. The back end scores a plane on one
// shared 35x17 multiplier, so the sustained rate is set by the number of
// distinct planes. The last event's own job yields a waiting result once
// any planes queued ahead of it are done, scoring its group first when it
// closes one. A finished result waits in its own output register, and new
// events are taken meanwhile until the queue fills. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sah_split_plane_sweep_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  sspsw_pkg::t_in    i_item,
    output logic              empty,
    input  logic              pop,
    output sspsw_pkg::t_out   o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    sspsw_pkg::t_cfg r_cfg;
    sspsw_pkg::t_job fr_job, q_job;
    logic            fr_push, q_full, q_empty, q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sspsw_pkg::REG_BOX_MIN_X: r_cfg.box_min[0] <= i_cfg_data;
                sspsw_pkg::REG_BOX_MIN_Y: r_cfg.box_min[1] <= i_cfg_data;
                sspsw_pkg::REG_BOX_MIN_Z: r_cfg.box_min[2] <= i_cfg_data;
                sspsw_pkg::REG_BOX_MAX_X: r_cfg.box_max[0] <= i_cfg_data;
                sspsw_pkg::REG_BOX_MAX_Y: r_cfg.box_max[1] <= i_cfg_data;
                sspsw_pkg::REG_BOX_MAX_Z: r_cfg.box_max[2] <= i_cfg_data;
                sspsw_pkg::REG_TRI_COUNT: r_cfg.tri_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sspsw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_tri_count (r_cfg.tri_count),
        .o_job_push  (fr_push),
        .o_job       (fr_job),
        .i_job_full  (q_full)
    );

    sspsw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_job   (fr_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    sspsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (q_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res)
    );

endmodule

// File: sv/sspsw_checker.sv
// ----------------------------------------------------------------------------
// sspsw_checker
// port-level checks of the split plane sweep, bound to the top level
// ----------------------------------------------------------------------------
module sspsw_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             empty,
    input  logic             pop,
    input  sspsw_pkg::t_out  o_res
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_res))
        else $error("waiting result changed");

    a_no_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.scaled_cost == sspsw_pkg::COST_MAX |->
        o_res.split_axis == sspsw_pkg::AXIS_X && o_res.split_position == '0 &&
        !o_res.planar_side)
        else $error("empty sweep reported a plane");

    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_res.split_axis != sspsw_pkg::AXIS_NONE)
        else $error("bad split axis");

endmodule

bind sah_split_plane_sweep_core sspsw_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);
